>>> hw/rtl/smm_pkg.sv
// ----------------------------------------------------------------------------
// smm_pkg: shared types and constants for the Strassen multiplier
// Opcodes, size limits, register indexes and payload structs.
// ----------------------------------------------------------------------------
package smm_pkg;
  localparam int MaxDim = 8;
  localparam logic [1:0] OP_LOAD_A  = 2'd0;
  localparam logic [1:0] OP_LOAD_B  = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;  // ignored, no result
  localparam logic [1:0] REG_ROWS_A = 2'd0;
  localparam logic [1:0] REG_COLS_A = 2'd1;
  localparam logic [1:0] REG_ROWS_B = 2'd2;
  localparam logic [1:0] REG_COLS_B = 2'd3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [2:0]         row_index;
    logic [2:0]         col_index;
    logic signed [15:0] elem_value;
  } smm_in_t;

  typedef struct packed {
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic signed [31:0] out_value;
    logic               last;
  } smm_out_t;
endpackage

>>> hw/rtl/smm_in_if.sv
// ----------------------------------------------------------------------------
// smm_in_if / smm_out_if: valid-ready channels
// One beat moves on valid and ready high.
// ----------------------------------------------------------------------------
interface smm_in_if;
  logic             valid;
  logic             ready;
  smm_pkg::smm_in_t data;
  modport source  (output valid, output data, input ready);
  modport sink    (input valid, input data, output ready);
  modport monitor (input valid, input data, input ready);
endinterface

interface smm_out_if;
  logic              valid;
  logic              ready;
  smm_pkg::smm_out_t data;
  modport source  (output valid, output data, input ready);
  modport sink    (input valid, input data, output ready);
  modport monitor (input valid, input data, input ready);
endinterface

>>> hw/rtl/smm_ram.sv
// ----------------------------------------------------------------------------
// smm_ram: generic single-port write, single read RAM
// Registered read data.
// ----------------------------------------------------------------------------
module smm_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/strassen_matrix_multiply_top.sv
// ----------------------------------------------------------------------------
// strassen_matrix_multiply_top: one-level Strassen matrix multiplier
// Loads A and B into RAMs, then computes and streams the product.
// ----------------------------------------------------------------------------
// in_ch.ready is high only while idle, so load beats are accepted back to
// back. A compute beat walks the zero-padded quarters in (i,j,z) steps. Each
// step fetches the four A and four B quarter elements (one read per cycle on
// each RAM, A and B in parallel, through the registered RAM read port), then
// runs seven multiply-accumulates through one shared 32x32 multiplier (one per
// cycle, with the product registered before it is added). After the HALF z
// steps of an (i,j) pair, the sums P1..P7 are written into the product RAM.
// Each output element then reads its four products, loads the combined sum
// into the output register and holds it valid until taken. No new beat is
// taken until the last element has left.
// Configuration: APB at byte address 4*i, registers rows_a, cols_a, rows_b,
// cols_b (4 bits, reset 8); 0 acts as 1, values above MAX_DIM as MAX_DIM.
// ----------------------------------------------------------------------------
module strassen_matrix_multiply_top #(
  parameter int MAX_DIM = smm_pkg::MaxDim
) (
  input  logic        clk,
  input  logic        rst_n,
  smm_in_if.sink      in_ch,
  smm_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import smm_pkg::*;

  localparam int HALF   = (MAX_DIM + 1) / 2;
  localparam int HW     = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int SDEP   = MAX_DIM * MAX_DIM;
  localparam int SAW    = $clog2(SDEP);
  localparam int PDEP   = 7 * HALF * HALF;
  localparam int PAW    = $clog2(PDEP);
  localparam int DW     = $clog2(MAX_DIM);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FET  = 3'd1;  // read 4 A / 4 B quarter elements
  localparam logic [2:0] S_MAC  = 3'd2;  // 7 multiply-accumulates
  localparam logic [2:0] S_WR   = 3'd3;  // write 7 sums to product RAM
  localparam logic [2:0] S_ERD  = 3'd4;  // read 4 products for one element
  localparam logic [2:0] S_EOUT = 3'd5;  // hold result for the sink

  logic [3:0] rows_a_r, cols_a_r, rows_b_r, cols_b_r;
  logic [2:0] st_r, st_nxt;

  // ---- configuration
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r <= 4'd8; cols_a_r <= 4'd8; rows_b_r <= 4'd8; cols_b_r <= 4'd8;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_paddr[3:2])
        REG_ROWS_A: rows_a_r <= cfg_pwdata[3:0];
        REG_COLS_A: cols_a_r <= cfg_pwdata[3:0];
        REG_ROWS_B: rows_b_r <= cfg_pwdata[3:0];
        REG_COLS_B: cols_b_r <= cfg_pwdata[3:0];
      endcase
    end
  end
  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_ROWS_A: cfg_prdata = {28'd0, rows_a_r};
      REG_COLS_A: cfg_prdata = {28'd0, cols_a_r};
      REG_ROWS_B: cfg_prdata = {28'd0, rows_b_r};
      default:    cfg_prdata = {28'd0, cols_b_r};
    endcase
  end

  function automatic logic [4:0] eff(input logic [3:0] v);
    if (v == 4'd0) return 5'd1;
    if (32'(v) > MAX_DIM) return 5'(MAX_DIM);
    return {1'b0, v};
  endfunction

  logic [4:0] nra, nca, nrb, ncb;
  assign nra = eff(rows_a_r);
  assign nca = eff(cols_a_r);
  assign nrb = eff(rows_b_r);
  assign ncb = eff(cols_b_r);

  // ---- counters
  logic [HW-1:0] i_r, j_r, z_r;
  logic [2:0]    sub_r;          // phase within a state
  logic [2:0]    dly_r;          // read-data phase (registered copy of sub)
  logic          dv_r;
  logic [2:0]    er_r, ec_r;     // emit row / column
  logic signed [31:0] qa_r [4];
  logic signed [31:0] qb_r [4];
  logic [31:0]   acc_r [7];
  logic [31:0]   mul_r;
  logic [31:0]   pv_r [4];
  smm_out_t      res_r;

  // ---- element RAMs
  logic          a_we, b_we;
  logic [SAW-1:0] waddr, a_ra, b_ra;
  logic [15:0]   a_rd, b_rd;
  logic          in_acc;

  assign in_ch.ready = (st_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign waddr = SAW'(32'(in_ch.data.row_index) * MAX_DIM + 32'(in_ch.data.col_index));
  assign a_we  = in_acc && in_ch.data.opcode == OP_LOAD_A &&
                 32'(in_ch.data.row_index) < MAX_DIM && 32'(in_ch.data.col_index) < MAX_DIM;
  assign b_we  = in_acc && in_ch.data.opcode == OP_LOAD_B &&
                 32'(in_ch.data.row_index) < MAX_DIM && 32'(in_ch.data.col_index) < MAX_DIM;

  // quarter q (sub_r) coordinates: bit0 adds HALF to column, bit1 to row
  logic [4:0] ar, ac, br, bc;
  assign ar = 5'(i_r) + (sub_r[1] ? 5'(HALF) : 5'd0);
  assign ac = 5'(z_r) + (sub_r[0] ? 5'(HALF) : 5'd0);
  assign br = 5'(z_r) + (sub_r[1] ? 5'(HALF) : 5'd0);
  assign bc = 5'(j_r) + (sub_r[0] ? 5'(HALF) : 5'd0);
  assign a_ra = SAW'(32'(ar[DW-1:0]) * MAX_DIM + 32'(ac[DW-1:0]));
  assign b_ra = SAW'(32'(br[DW-1:0]) * MAX_DIM + 32'(bc[DW-1:0]));

  logic ain_r, bin_r;  // registered in-range flags matching read data

  smm_ram #(.Width(16), .Depth(SDEP)) u_ram_a (
    .clk, .we(a_we), .waddr, .wdata(in_ch.data.elem_value),
    .raddr(a_ra), .rdata(a_rd));
  smm_ram #(.Width(16), .Depth(SDEP)) u_ram_b (
    .clk, .we(b_we), .waddr, .wdata(in_ch.data.elem_value),
    .raddr(b_ra), .rdata(b_rd));

  // ---- product RAM
  logic           p_we;
  logic [PAW-1:0] p_wa, p_ra;
  logic [31:0]    p_wd, p_rd;
  logic [HW-1:0]  ei, ej;
  logic [2:0]     pn;
  assign ei = HW'((er_r >= 3'(HALF)) ? er_r - 3'(HALF) : er_r);
  assign ej = HW'((ec_r >= 3'(HALF)) ? ec_r - 3'(HALF) : ec_r);
  assign p_we = (st_r == S_WR);
  assign p_wa = PAW'((32'(sub_r) * HALF + 32'(i_r)) * HALF + 32'(j_r));
  assign p_wd = acc_r[sub_r];

  // which four products an output element needs, by quarter and slot
  logic lr, lc;
  assign lr = 32'(er_r) < HALF;
  assign lc = 32'(ec_r) < HALF;
  always_comb begin
    priority if (lr && lc) begin
      unique case (sub_r[1:0])
        2'd0: pn = 3'd0; 2'd1: pn = 3'd3; 2'd2: pn = 3'd4; default: pn = 3'd6;
      endcase
    end else if (lr) begin
      pn = sub_r[0] ? 3'd4 : 3'd2;
    end else if (lc) begin
      pn = sub_r[0] ? 3'd3 : 3'd1;
    end else begin
      unique case (sub_r[1:0])
        2'd0: pn = 3'd0; 2'd1: pn = 3'd1; 2'd2: pn = 3'd2; default: pn = 3'd5;
      endcase
    end
  end
  assign p_ra = PAW'((32'(pn) * HALF + 32'(ei)) * HALF + 32'(ej));

  smm_ram #(.Width(32), .Depth(PDEP)) u_ram_p (
    .clk, .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));

  // ---- multiplier operands per product
  logic [31:0] opa, opb;
  always_comb begin
    unique case (sub_r)
      3'd0: begin opa = qa_r[0] + qa_r[3]; opb = qb_r[0] + qb_r[3]; end
      3'd1: begin opa = qa_r[2] + qa_r[3]; opb = qb_r[0]; end
      3'd2: begin opa = qa_r[0];           opb = qb_r[1] - qb_r[3]; end
      3'd3: begin opa = qa_r[3];           opb = qb_r[2] - qb_r[0]; end
      3'd4: begin opa = qa_r[0] + qa_r[1]; opb = qb_r[3]; end
      3'd5: begin opa = qa_r[2] - qa_r[0]; opb = qb_r[0] + qb_r[1]; end
      default: begin opa = qa_r[1] - qa_r[3]; opb = qb_r[2] + qb_r[3]; end
    endcase
  end

  logic last_z, last_ij;
  assign last_z  = (32'(z_r) == HALF - 1);
  assign last_ij = (32'(i_r) == HALF - 1) && (32'(j_r) == HALF - 1);

  // combined result, valid when all four products are in pv_r
  logic [31:0] comb_v;
  always_comb begin
    priority if (lr && lc) comb_v = pv_r[0] + pv_r[1] - pv_r[2] + pv_r[3];
    else if (lr || lc)     comb_v = pv_r[0] + pv_r[1];
    else                   comb_v = pv_r[0] - pv_r[1] + pv_r[2] + pv_r[3];
  end

  // ---- sequencer
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (in_acc && in_ch.data.opcode == OP_COMPUTE) st_nxt = S_FET;
      S_FET:  if (dv_r && dly_r == 3'd3) st_nxt = S_MAC;
      S_MAC:  if (dv_r && dly_r == 3'd6) st_nxt = last_z ? S_WR : S_FET;
      S_WR:   if (sub_r == 3'd6) st_nxt = last_ij ? S_ERD : S_FET;
      S_ERD:  if (dv_r && dly_r == 3'd3) st_nxt = S_EOUT;
      S_EOUT: if (out_ch.ready && dv_r)
                st_nxt = res_r.last ? S_IDLE : S_ERD;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; sub_r <= '0; dly_r <= '0; dv_r <= 1'b0;
      i_r <= '0; j_r <= '0; z_r <= '0; er_r <= '0; ec_r <= '0;
    end else begin
      st_r <= st_nxt;
      dly_r <= sub_r;
      unique case (st_r)
        S_IDLE: begin
          sub_r <= '0; dv_r <= 1'b0;
          i_r <= '0; j_r <= '0; z_r <= '0; er_r <= '0; ec_r <= '0;
        end
        S_FET: begin
          // issue reads at sub 0..3, read data returns in the next cycle
          if (dv_r && dly_r == 3'd3) begin
            sub_r <= '0; dv_r <= 1'b0;
          end else begin
            dv_r <= 1'b1;
            if (sub_r != 3'd3) sub_r <= sub_r + 3'd1;
          end
        end
        S_MAC: begin
          // product n formed at sub n, added in the next cycle
          if (dv_r && dly_r == 3'd6) begin
            sub_r <= '0; dv_r <= 1'b0;
            if (!last_z) z_r <= z_r + HW'(1);
          end else begin
            dv_r <= 1'b1;
            if (sub_r != 3'd6) sub_r <= sub_r + 3'd1;
          end
        end
        S_WR: begin
          if (sub_r == 3'd6) begin
            sub_r <= '0; z_r <= '0;
            if (32'(j_r) == HALF - 1) begin
              j_r <= '0; i_r <= i_r + HW'(1);
            end else begin
              j_r <= j_r + HW'(1);
            end
          end else begin
            sub_r <= sub_r + 3'd1;
          end
        end
        S_ERD: begin
          if (dv_r && dly_r == 3'd3) begin
            sub_r <= '0; dv_r <= 1'b0;
          end else begin
            dv_r <= 1'b1;
            if (sub_r != 3'd3) sub_r <= sub_r + 3'd1;
          end
        end
        S_EOUT: begin
          // dv_r marks result register loaded
          if (out_ch.ready && dv_r) begin
            dv_r <= 1'b0;
            if (5'(ec_r) == ncb - 5'd1) begin
              ec_r <= '0; er_r <= er_r + 3'd1;
            end else begin
              ec_r <= ec_r + 3'd1;
            end
          end else begin
            dv_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    ain_r <= (ar < nra) && (ac < nca);
    bin_r <= (br < nrb) && (bc < ncb);
    mul_r <= opa * opb;
    if (st_r == S_FET && dv_r) begin
      qa_r[dly_r[1:0]] <= ain_r ? 32'(signed'(a_rd)) : 32'sd0;
      qb_r[dly_r[1:0]] <= bin_r ? 32'(signed'(b_rd)) : 32'sd0;
    end
    if (st_r == S_MAC && dv_r)
      acc_r[dly_r] <= (z_r == '0 ? 32'd0 : acc_r[dly_r]) + mul_r;
    if (st_r == S_ERD && dv_r) pv_r[dly_r[1:0]] <= p_rd;
    if (st_r == S_EOUT && !dv_r) begin
      res_r.out_row   <= er_r;
      res_r.out_col   <= ec_r;
      res_r.out_value <= comb_v;
      res_r.last      <= (5'(er_r) == nra - 5'd1) && (5'(ec_r) == ncb - 5'd1);
    end
  end

  assign out_ch.valid = (st_r == S_EOUT) && dv_r;
  assign out_ch.data  = res_r;

  // ---- checks
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != S_IDLE |-> !in_ch.ready) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(res_r))
    else $error("result dropped");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && res_r.last |=> st_r == S_IDLE)
    else $error("no return to idle after last");
  a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> 5'(res_r.out_row) < nra && 5'(res_r.out_col) < ncb)
    else $error("emit index out of range");
endmodule
